[src/csa_pkg.sv]
`timescale 1ns / 1ps

package csa_pkg;

    // Window length and the widths that follow from it.
    localparam int WINDOW = 6;
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);

    // Largest magnitude a window sum can reach (temperature high end dominates).
    localparam int SUM_MAX   = WINDOW * 13000;
    localparam int SUM_W     = $clog2(SUM_MAX + 1);
    localparam int TSUM_W    = SUM_W + 1;

    // Averaging divider: two quotient bits per cycle.
    localparam int DIV_RADIX = 2;
    localparam int DIV_STEPS = (SUM_W + DIV_RADIX - 1) / DIV_RADIX;
    localparam int DIV_W     = DIV_STEPS * DIV_RADIX;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Fake temperature sawtooth.
    localparam logic [11:0] FAKE_START = 12'd2400;
    localparam logic [11:0] FAKE_LIMIT = 12'd2800;
    localparam logic [11:0] FAKE_STEP  = 12'd5;

    // Status codes reported with each result.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ABSENT   = 2'd1,
        ST_TEMP_CRC = 2'd2,
        ST_HUM_CRC  = 2'd3
    } status_t;

    // One classified and scaled frame, passed from front to back.
    typedef struct packed {
        status_t            status;
        logic signed [14:0] temp;
        logic [13:0]        hum;
    } csa_entry_t;

endpackage

[src/csa_front.sv]
`timescale 1ns / 1ps

module csa_front import csa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sensor_present,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] temp_high_byte,
    input  logic [7:0] temp_low_byte,
    input  logic [7:0] temp_check_byte,
    input  logic [7:0] hum_high_byte,
    input  logic [7:0] hum_low_byte,
    input  logic [7:0] hum_check_byte,
    input  logic       read_failed,
    output logic       push_valid,
    input  logic       push_ready,
    output csa_entry_t push_data
);

    localparam logic [7:0]         CRC_POLY    = 8'h31;
    localparam logic [7:0]         CRC_INIT    = 8'hFF;
    localparam logic [14:0]        TEMP_SPAN   = 15'd17500;
    localparam logic [13:0]        HUM_SPAN    = 14'd10000;
    localparam logic [16:0]        RAW_FULL    = 17'd65535;
    localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_CRC  = 5'b00010,
        F_MUL  = 5'b00100,
        F_DIV  = 5'b01000,
        F_PUSH = 5'b10000
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [1:0]   cnt_reg, cnt_next;

    logic [15:0]  traw_reg, hraw_reg;
    logic [15:0]  tshift_reg, hshift_reg;
    logic [7:0]   tcrc_reg, hcrc_reg;
    logic [7:0]   tchk_reg, hchk_reg;
    logic         fail_reg;
    logic [30:0]  tprod_reg;
    logic [29:0]  hprod_reg;
    csa_entry_t   entry_reg;

    logic [15:0]        tq, hq;
    logic signed [15:0] tval;
    status_t            stat;

    // Four CRC steps, data bits taken most significant first.
    function automatic logic [7:0] crc_step4(input logic [7:0] crc, input logic [3:0] data);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 3; i >= 0; i--)
        begin
            fb = c[7] ^ data[i];
            c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    // Floor division by 65535 for products below 65535 * 65536, with one correction.
    function automatic logic [15:0] div_full(input logic [31:0] x);
        logic [15:0] q0;
        logic [16:0] r0;
        q0 = x[31:16];
        r0 = {1'b0, x[15:0]} + {1'b0, q0};
        return q0 + 16'(r0 >= RAW_FULL);
    endfunction

    assign in_ready   = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_PUSH);
    assign push_data  = entry_reg;

    // Sequencer state.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                cnt_next = 2'd0;
                if (in_valid)
                begin
                    state_next = F_CRC;
                end
            end
            F_CRC:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = F_MUL;
                end
            end
            F_MUL:  state_next = F_DIV;
            F_DIV:  state_next = F_PUSH;
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Scaled values and the failure that comes first in precedence.
    always_comb
    begin
        tq   = div_full(32'(tprod_reg));
        hq   = div_full(32'(hprod_reg));
        tval = $signed({1'b0, tq[14:0]}) - TEMP_OFFSET;
        if (fail_reg)
        begin
            stat = ST_ABSENT;
        end
        else if (tcrc_reg != tchk_reg)
        begin
            stat = ST_TEMP_CRC;
        end
        else if (hcrc_reg != hchk_reg)
        begin
            stat = ST_HUM_CRC;
        end
        else
        begin
            stat = ST_OK;
        end
    end

    // Frame capture, CRC iteration, scaling multiply and the queue entry.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            traw_reg   <= {temp_high_byte, temp_low_byte};
            hraw_reg   <= {hum_high_byte, hum_low_byte};
            tshift_reg <= {temp_high_byte, temp_low_byte};
            hshift_reg <= {hum_high_byte, hum_low_byte};
            tchk_reg   <= temp_check_byte;
            hchk_reg   <= hum_check_byte;
            fail_reg   <= read_failed | ~sensor_present;
            tcrc_reg   <= CRC_INIT;
            hcrc_reg   <= CRC_INIT;
        end
        if (state_reg == F_CRC)
        begin
            tcrc_reg   <= crc_step4(tcrc_reg, tshift_reg[15:12]);
            hcrc_reg   <= crc_step4(hcrc_reg, hshift_reg[15:12]);
            tshift_reg <= {tshift_reg[11:0], 4'h0};
            hshift_reg <= {hshift_reg[11:0], 4'h0};
        end
        if (state_reg == F_MUL)
        begin
            tprod_reg <= 31'(traw_reg) * 31'(TEMP_SPAN);
            hprod_reg <= 30'(hraw_reg) * 30'(HUM_SPAN);
        end
        if (state_reg == F_DIV)
        begin
            entry_reg.status <= stat;
            entry_reg.temp   <= tval[14:0];
            entry_reg.hum    <= hq[13:0];
        end
    end

endmodule

[src/csa_queue.sv]
`timescale 1ns / 1ps

module csa_queue import csa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  csa_entry_t push_data,
    output logic       pop_valid,
    input  logic       pop_ready,
    output csa_entry_t pop_data
);

    csa_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg < QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[src/csa_back.sv]
`timescale 1ns / 1ps

module csa_back import csa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  csa_entry_t         pop_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [14:0] temp_used,
    output logic [13:0]        hum_used,
    output logic signed [14:0] temp_average,
    output logic [13:0]        hum_average,
    output logic [1:0]         status
);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_DIV  = 3'b010,
        B_DONE = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;

    // Window storage and running sums.
    logic signed [14:0]        temp_win_reg [WINDOW];
    logic [13:0]               hum_win_reg  [WINDOW];
    logic [SLOT_W-1:0]         slot_reg, slot_next;
    logic [CNT_W-1:0]          filled_reg, filled_next;
    logic [11:0]               fake_reg, fake_next;
    logic signed [TSUM_W-1:0]  tsum_reg, tsum_next;
    logic [SUM_W-1:0]          hsum_reg, hsum_next;

    // Divider registers.
    logic [DIV_W-1:0]          tq_reg, hq_reg, tq_next, hq_next;
    logic [CNT_W-1:0]          trem_reg, hrem_reg, trem_next, hrem_next;
    logic [CNT_W-1:0]          div_n_reg;
    logic                      neg_reg;
    logic [STEP_W-1:0]         step_reg, step_next;

    // Result registers.
    logic signed [14:0]        tsmp_reg, tavg_reg;
    logic [13:0]               hsmp_reg, havg_reg;
    status_t                   stat_reg;

    logic                      do_pop, last_step, fail, full;
    logic [11:0]               fake_step;
    logic signed [14:0]        new_temp, old_temp;
    logic [13:0]               new_hum, old_hum;
    logic signed [TSUM_W-1:0]  tneg;
    logic [SUM_W-1:0]          tmag;
    logic [CNT_W:0]            t_s, h_s;
    logic [DIV_W-1:0]          t_q, h_q;
    logic [CNT_W-1:0]          t_r, h_r;
    logic signed [DIV_W:0]     tavg_w;

    assign pop_ready    = (state_reg == B_IDLE);
    assign do_pop       = pop_valid & pop_ready;
    assign last_step    = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign out_valid    = (state_reg == B_DONE);
    assign temp_used    = tsmp_reg;
    assign hum_used     = hsmp_reg;
    assign temp_average = tavg_reg;
    assign hum_average  = havg_reg;
    assign status       = stat_reg;

    // Sample selection, window update and running sums for a popped entry.
    always_comb
    begin
        fail      = (pop_data.status != ST_OK);
        fake_step = fake_reg + FAKE_STEP;
        fake_next = (fake_step > FAKE_LIMIT) ? FAKE_START : fake_step;
        new_temp  = fail ? $signed({3'b000, fake_next}) : pop_data.temp;
        new_hum   = fail ? 14'd0 : pop_data.hum;
        full      = (filled_reg == CNT_W'(WINDOW));
        old_temp  = full ? temp_win_reg[slot_reg] : 15'sd0;
        old_hum   = full ? hum_win_reg[slot_reg] : 14'd0;
        tsum_next = tsum_reg - TSUM_W'(old_temp) + TSUM_W'(new_temp);
        hsum_next = hsum_reg - SUM_W'(old_hum) + SUM_W'(new_hum);
        filled_next = full ? filled_reg : filled_reg + 1'b1;
        slot_next = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
        tneg      = -tsum_next;
        tmag      = tsum_next[TSUM_W-1] ? tneg[SUM_W-1:0] : tsum_next[SUM_W-1:0];
    end

    // Restoring division, two quotient bits per cycle for both sums.
    always_comb
    begin
        t_q = tq_reg;
        h_q = hq_reg;
        t_r = trem_reg;
        h_r = hrem_reg;
        t_s = '0;
        h_s = '0;
        for (int k = 0; k < DIV_RADIX; k++)
        begin
            t_s = {t_r, t_q[DIV_W-1]};
            h_s = {h_r, h_q[DIV_W-1]};
            t_q = {t_q[DIV_W-2:0], 1'b0};
            h_q = {h_q[DIV_W-2:0], 1'b0};
            if (t_s >= {1'b0, div_n_reg})
            begin
                t_s    = t_s - {1'b0, div_n_reg};
                t_q[0] = 1'b1;
            end
            if (h_s >= {1'b0, div_n_reg})
            begin
                h_s    = h_s - {1'b0, div_n_reg};
                h_q[0] = 1'b1;
            end
            t_r = t_s[CNT_W-1:0];
            h_r = h_s[CNT_W-1:0];
        end
        tq_next   = t_q;
        hq_next   = h_q;
        trem_next = t_r;
        hrem_next = h_r;
        tavg_w    = neg_reg ? -$signed({1'b0, tq_next}) : $signed({1'b0, tq_next});
    end

    // Back part sequencer.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                step_next = '0;
                if (pop_valid)
                begin
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (last_step)
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (out_ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Control state and running window state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            step_reg   <= '0;
            slot_reg   <= '0;
            filled_reg <= '0;
            fake_reg   <= FAKE_START;
            tsum_reg   <= '0;
            hsum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (do_pop)
            begin
                slot_reg   <= slot_next;
                filled_reg <= filled_next;
                tsum_reg   <= tsum_next;
                hsum_reg   <= hsum_next;
                if (fail)
                begin
                    fake_reg <= fake_next;
                end
            end
        end
    end

    // Window entries, divider operands and result fields.
    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            temp_win_reg[slot_reg] <= new_temp;
            hum_win_reg[slot_reg]  <= new_hum;
            tq_reg    <= DIV_W'(tmag);
            hq_reg    <= DIV_W'(hsum_next);
            trem_reg  <= '0;
            hrem_reg  <= '0;
            div_n_reg <= filled_next;
            neg_reg   <= tsum_next[TSUM_W-1];
            tsmp_reg  <= new_temp;
            hsmp_reg  <= new_hum;
            stat_reg  <= pop_data.status;
        end
        if (state_reg == B_DIV)
        begin
            tq_reg   <= tq_next;
            hq_reg   <= hq_next;
            trem_reg <= trem_next;
            hrem_reg <= hrem_next;
            if (last_step)
            begin
                tavg_reg <= tavg_w[14:0];
                havg_reg <= hq_next[13:0];
            end
        end
    end

endmodule

[src/checked_sensor_sample_averager.sv]
`timescale 1ns / 1ps

// Channel   Signals                               Payload
// --------  ------------------------------------  ------------------------------------------
// input     in_valid / in_ready                   six frame bytes, read_failed
// output    out_valid / out_ready                 temp_used, hum_used, temp_average,
//                                                 hum_average, status
// config    cfg_valid / cfg_ready                 cfg_data (sensor_present)
//
// The front part takes a new request only once the last one is pushed: capture, four CRC steps
// at four bits each, one scaling multiply and one divide-by-65535 correction, then a queue push.
// The back part takes a new request only once its result has left the output, and its
// two-bits-per-cycle averaging divider sets the sustained rate.
// A two-entry queue between the parts lets the front keep taking requests while a
// result waits at the output. Reset is asynchronous and needs no clearing pass.

module checked_sensor_sample_averager import csa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         temp_high_byte,
    input  logic [7:0]         temp_low_byte,
    input  logic [7:0]         temp_check_byte,
    input  logic [7:0]         hum_high_byte,
    input  logic [7:0]         hum_low_byte,
    input  logic [7:0]         hum_check_byte,
    input  logic               read_failed,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [14:0] temp_used,
    output logic [13:0]        hum_used,
    output logic signed [14:0] temp_average,
    output logic [13:0]        hum_average,
    output logic [1:0]         status
);

    logic       present_reg;
    logic       push_valid, push_ready, pop_valid, pop_ready;
    csa_entry_t push_data, pop_data;

    // The configuration register is always ready to take a write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            present_reg <= cfg_data;
        end
    end

    // Front part: CRC check, classification and scaling.
    csa_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .sensor_present  (present_reg),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .temp_high_byte  (temp_high_byte),
        .temp_low_byte   (temp_low_byte),
        .temp_check_byte (temp_check_byte),
        .hum_high_byte   (hum_high_byte),
        .hum_low_byte    (hum_low_byte),
        .hum_check_byte  (hum_check_byte),
        .read_failed     (read_failed),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_data       (push_data)
    );

    // Queue between the two parts.
    csa_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Back part: fake samples, windows and averaging.
    csa_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .temp_used    (temp_used),
        .hum_used     (hum_used),
        .temp_average (temp_average),
        .hum_average  (hum_average),
        .status       (status)
    );

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
    import csa_pkg::*;

    // Run limits and the long output hold-off.
    localparam int CYCLE_LIMIT = 300000;
    localparam int REPORT_MAX  = 10;
    localparam int HOLD_AT     = 1200;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 40;

    // Sensor arithmetic as the block defines it.
    localparam logic [7:0] CRC_POLY    = 8'h31;
    localparam logic [7:0] CRC_SEED    = 8'hFF;
    localparam int         TEMP_SPAN   = 17500;
    localparam int         TEMP_OFFSET = 4500;
    localparam int         HUM_SPAN    = 10000;
    localparam int         RAW_FULL    = 65535;
    localparam int         FAKE_BASE   = 2400;
    localparam int         FAKE_TOP    = 2800;
    localparam int         FAKE_INC    = 5;

    // How a check byte is produced for a stimulus frame.
    typedef enum logic [1:0] {
        CHK_GOOD,
        CHK_FLIP,
        CHK_RAW
    } check_mode_t;

    typedef struct packed {
        logic [7:0] th;
        logic [7:0] tl;
        logic [7:0] tc;
        logic [7:0] hh;
        logic [7:0] hl;
        logic [7:0] hc;
        logic       fail;
    } frame_t;

    typedef struct packed {
        logic signed [14:0] temp;
        logic [13:0]        hum;
        logic signed [14:0] temp_avg;
        logic [13:0]        hum_avg;
        status_t            st;
    } reading_t;

    typedef struct packed {
        frame_t             frame;
        check_mode_t        tmode;
        check_mode_t        hmode;
        logic               present;
        logic               typed;
        logic signed [14:0] temp;
        logic [13:0]        hum;
        status_t            st;
    } frame_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_data = 1'b1;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         temp_high_byte = 8'h00;
    logic [7:0]         temp_low_byte = 8'h00;
    logic [7:0]         temp_check_byte = 8'h00;
    logic [7:0]         hum_high_byte = 8'h00;
    logic [7:0]         hum_low_byte = 8'h00;
    logic [7:0]         hum_check_byte = 8'h00;
    logic               read_failed = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [14:0] temp_used;
    logic [13:0]        hum_used;
    logic signed [14:0] temp_average;
    logic [13:0]        hum_average;
    logic [1:0]         status;

    // Predictor state: its own copy of the register, windows and sawtooth.
    logic present_q = 1'b1;
    int   temp_hist [WINDOW];
    int   hum_hist [WINDOW];
    int   slot = 0;
    int   filled = 0;
    int   fake_temp = FAKE_BASE;

    reading_t   pending_readings [$];
    frame_row_t typed_notes [$];
    int         frames_sent = 0;
    int         readings_taken = 0;
    int         fail_count = 0;
    int         reported = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         sink_taken = 0;
    int         hold_left = 0;
    bit         hold_used = 1'b0;

    checked_sensor_sample_averager dut (.*);

    always #1 clk = ~clk;

    // CRC-8 over the high byte then the low byte, most significant bit first.
    function automatic logic [7:0] word_crc(logic [7:0] hi, logic [7:0] lo);
        logic [7:0]  crc;
        logic [15:0] word;
        int          i;
        crc = CRC_SEED;
        word = {hi, lo};
        for (i = 15; i >= 0; i--)
        begin
            crc = (crc[7] ^ word[i]) ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
        end
        return crc;
    endfunction

    // Fill in the check bytes; a flipped byte is the good CRC xored with the given mask.
    function automatic frame_t apply_checks(frame_t f, check_mode_t tm, check_mode_t hm);
        if (tm == CHK_GOOD)
            f.tc = word_crc(f.th, f.tl);
        else if (tm == CHK_FLIP)
            f.tc = word_crc(f.th, f.tl) ^ f.tc;
        if (hm == CHK_GOOD)
            f.hc = word_crc(f.hh, f.hl);
        else if (hm == CHK_FLIP)
            f.hc = word_crc(f.hh, f.hl) ^ f.hc;
        return f;
    endfunction

    // Classify, scale or fake, push into the windows and average what is held.
    function automatic reading_t predict_reading(frame_t f);
        reading_t r;
        status_t  st;
        int       t;
        int       h;
        int       raw_t;
        int       raw_h;
        int       tsum;
        int       hsum;
        int       i;
        if (!present_q || f.fail)
            st = ST_ABSENT;
        else if (word_crc(f.th, f.tl) != f.tc)
            st = ST_TEMP_CRC;
        else if (word_crc(f.hh, f.hl) != f.hc)
            st = ST_HUM_CRC;
        else
            st = ST_OK;
        if (st != ST_OK)
        begin
            fake_temp += FAKE_INC;
            if (fake_temp > FAKE_TOP)
                fake_temp = FAKE_BASE;
            t = fake_temp;
            h = 0;
        end
        else
        begin
            raw_t = {f.th, f.tl};
            raw_h = {f.hh, f.hl};
            t = (TEMP_SPAN * raw_t) / RAW_FULL - TEMP_OFFSET;
            h = (HUM_SPAN * raw_h) / RAW_FULL;
        end
        temp_hist[slot] = t;
        hum_hist[slot] = h;
        slot = (slot + 1) % WINDOW;
        if (filled < WINDOW)
            filled++;
        tsum = 0;
        hsum = 0;
        for (i = 0; i < filled; i++)
        begin
            tsum += temp_hist[i];
            hsum += hum_hist[i];
        end
        r.temp = 15'(t);
        r.hum = 14'(h);
        r.temp_avg = 15'(tsum / filled);
        r.hum_avg = 14'(hsum / filled);
        r.st = st;
        return r;
    endfunction

    function automatic frame_row_t mk_row(logic present, logic [7:0] th, logic [7:0] tl,
                                          check_mode_t tm, logic [7:0] tc,
                                          logic [7:0] hh, logic [7:0] hl,
                                          check_mode_t hm, logic [7:0] hc, logic fail,
                                          logic typed, int temp, int hum, status_t st);
        frame_row_t row;
        row.frame = '{th: th, tl: tl, tc: tc, hh: hh, hl: hl, hc: hc, fail: fail};
        row.tmode = tm;
        row.hmode = hm;
        row.present = present;
        row.typed = typed;
        row.temp = 15'(temp);
        row.hum = 14'(hum);
        row.st = st;
        return row;
    endfunction

    // Mostly well-formed frames, some failed reads and bad checks, a little noise.
    function automatic frame_t random_frame();
        frame_t      f;
        check_mode_t tm;
        check_mode_t hm;
        int          pick;
        int          kind;
        pick = $urandom_range(99);
        if (pick < 20)
            {f.th, f.tl} = 16'($urandom_range(16'h3FFF));
        else if (pick < 25)
            {f.th, f.tl} = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        else
            {f.th, f.tl} = 16'($urandom);
        if ($urandom_range(99) < 5)
            {f.hh, f.hl} = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        else
            {f.hh, f.hl} = 16'($urandom);
        f.tc = 8'($urandom_range(255, 1));
        f.hc = 8'($urandom_range(255, 1));
        f.fail = 1'b0;
        tm = CHK_GOOD;
        hm = CHK_GOOD;
        kind = $urandom_range(99);
        if (kind < 3)
        begin
            f.tc = 8'($urandom);
            f.hc = 8'($urandom);
            f.fail = 1'($urandom);
            tm = CHK_RAW;
            hm = CHK_RAW;
        end
        else if (kind < 13)
        begin
            f.fail = 1'b1;
            tm = check_mode_t'($urandom_range(1));
            hm = check_mode_t'($urandom_range(1));
        end
        else if (kind < 23)
        begin
            tm = CHK_FLIP;
            hm = check_mode_t'($urandom_range(1));
        end
        else if (kind < 33)
        begin
            hm = CHK_FLIP;
        end
        return apply_checks(f, tm, hm);
    endfunction

    // Offer one request after a random gap and hold it until it is taken.
    task automatic send_frame(frame_t f);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        temp_high_byte <= f.th;
        temp_low_byte <= f.tl;
        temp_check_byte <= f.tc;
        hum_high_byte <= f.hh;
        hum_low_byte <= f.hl;
        hum_check_byte <= f.hc;
        read_failed <= f.fail;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        frames_sent++;
    endtask

    // Stop offering and wait until every request has produced its reading.
    task automatic wait_all_taken();
        in_valid <= 1'b0;
        while (readings_taken < frames_sent)
            @(posedge clk);
    endtask

    task automatic write_presence(logic value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Compare readings against the predictor and feed it every accepted request.
    always @(posedge clk)
    begin : scoreboard
        reading_t   want;
        reading_t   got;
        frame_t     seen;
        frame_row_t note;
        if (out_valid && out_ready)
        begin
            readings_taken++;
            got = {temp_used, hum_used, temp_average, hum_average, status};
            if (pending_readings.size() == 0)
            begin
                fail_count++;
                if (reported < REPORT_MAX)
                begin
                    reported++;
                    $display("[%0t] unexpected reading: temp %0d hum %0d st %0d",
                             $realtime, got.temp, got.hum, got.st);
                end
            end
            else
            begin
                want = pending_readings.pop_front();
                if (got.temp !== want.temp || got.hum !== want.hum ||
                    got.temp_avg !== want.temp_avg || got.hum_avg !== want.hum_avg ||
                    got.st !== want.st)
                begin
                    fail_count++;
                    if (reported < REPORT_MAX)
                    begin
                        reported++;
                        $write("[%0t] reading %0d mismatch (expected/actual): temp %0d/%0d",
                               $realtime, readings_taken, want.temp, got.temp);
                        $display(" hum %0d/%0d tavg %0d/%0d havg %0d/%0d st %0d/%0d",
                                 want.hum, got.hum, want.temp_avg, got.temp_avg,
                                 want.hum_avg, got.hum_avg, want.st, got.st);
                    end
                end
            end
        end
        if (in_valid && in_ready)
        begin
            seen = {temp_high_byte, temp_low_byte, temp_check_byte,
                    hum_high_byte, hum_low_byte, hum_check_byte, read_failed};
            want = predict_reading(seen);
            // Directed rows may carry sample and status values typed in by hand.
            if (typed_notes.size() != 0)
            begin
                note = typed_notes.pop_front();
                if (note.typed)
                begin
                    want.temp = note.temp;
                    want.hum = note.hum;
                    want.st = note.st;
                end
            end
            pending_readings.push_back(want);
        end
        if (cfg_valid && cfg_ready)
            present_q = cfg_data;
    end

    // Output side: random back-pressure plus one long hold-off to fill the block.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sink_taken++;
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (!hold_used && sink_taken >= HOLD_AT)
        begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        frame_row_t directed_rows [$];
        frame_row_t row;
        logic       presence_now;
        int         seg_items [6];
        logic       seg_present [6];
        int         s;
        int         k;

        seg_items = '{400, 60, 400, 60, 400, 330};
        seg_present = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

        // Extremes, every failure kind and its precedence, absent sensor, cold window.
        directed_rows.push_back(mk_row(1, 8'h00, 8'h00, CHK_GOOD, 8'h00, 8'h00, 8'h00,
                                       CHK_GOOD, 8'h00, 0, 1, -4500, 0, ST_OK));
        directed_rows.push_back(mk_row(1, 8'hFF, 8'hFF, CHK_GOOD, 8'h00, 8'hFF, 8'hFF,
                                       CHK_GOOD, 8'h00, 0, 1, 13000, 10000, ST_OK));
        directed_rows.push_back(mk_row(1, 8'hBE, 8'hEF, CHK_RAW, 8'h92, 8'hBE, 8'hEF,
                                       CHK_RAW, 8'h92, 0, 1, 8552, 7458, ST_OK));
        directed_rows.push_back(mk_row(1, 8'h12, 8'h34, CHK_GOOD, 8'h00, 8'h56, 8'h78,
                                       CHK_GOOD, 8'h00, 1, 1, 2405, 0, ST_ABSENT));
        directed_rows.push_back(mk_row(1, 8'h12, 8'h34, CHK_FLIP, 8'h01, 8'h56, 8'h78,
                                       CHK_GOOD, 8'h00, 0, 1, 2410, 0, ST_TEMP_CRC));
        directed_rows.push_back(mk_row(1, 8'h12, 8'h34, CHK_GOOD, 8'h00, 8'h56, 8'h78,
                                       CHK_FLIP, 8'h80, 0, 1, 2415, 0, ST_HUM_CRC));
        directed_rows.push_back(mk_row(1, 8'hAB, 8'hCD, CHK_FLIP, 8'hFF, 8'hEF, 8'h01,
                                       CHK_FLIP, 8'hFF, 0, 1, 2420, 0, ST_TEMP_CRC));
        directed_rows.push_back(mk_row(1, 8'hAB, 8'hCD, CHK_FLIP, 8'h40, 8'hEF, 8'h01,
                                       CHK_FLIP, 8'h02, 1, 1, 2425, 0, ST_ABSENT));
        directed_rows.push_back(mk_row(0, 8'h80, 8'h00, CHK_GOOD, 8'h00, 8'h80, 8'h00,
                                       CHK_GOOD, 8'h00, 0, 1, 2430, 0, ST_ABSENT));
        directed_rows.push_back(mk_row(0, 8'h80, 8'h00, CHK_FLIP, 8'hFF, 8'h80, 8'h00,
                                       CHK_FLIP, 8'hFF, 1, 1, 2435, 0, ST_ABSENT));
        directed_rows.push_back(mk_row(1, 8'h00, 8'h01, CHK_GOOD, 8'h00, 8'h00, 8'h01,
                                       CHK_GOOD, 8'h00, 0, 1, -4500, 0, ST_OK));
        directed_rows.push_back(mk_row(1, 8'h80, 8'h00, CHK_GOOD, 8'h00, 8'h80, 8'h00,
                                       CHK_GOOD, 8'h00, 0, 1, 4250, 5000, ST_OK));
        directed_rows.push_back(mk_row(1, 8'hFF, 8'hFE, CHK_GOOD, 8'h00, 8'hFF, 8'hFE,
                                       CHK_GOOD, 8'h00, 0, 1, 12999, 9999, ST_OK));
        for (k = 0; k < 5; k++)
        begin
            directed_rows.push_back(mk_row(1, 8'h00, 8'h00, CHK_GOOD, 8'h00, 8'hFF, 8'hFF,
                                           CHK_GOOD, 8'h00, 0, 1, -4500, 10000, ST_OK));
        end
        directed_rows.push_back(mk_row(1, 8'h3C, 8'hA5, CHK_GOOD, 8'h00, 8'hC3, 8'h5A,
                                       CHK_GOOD, 8'h00, 0, 0, 0, 0, ST_OK));
        directed_rows.push_back(mk_row(1, 8'h5A, 8'hC3, CHK_GOOD, 8'h00, 8'hA5, 8'h3C,
                                       CHK_GOOD, 8'h00, 0, 0, 0, 0, ST_OK));
        directed_rows.push_back(mk_row(1, 8'h7F, 8'hFF, CHK_GOOD, 8'h00, 8'h00, 8'hFF,
                                       CHK_GOOD, 8'h00, 0, 0, 0, 0, ST_OK));
        directed_rows.push_back(mk_row(1, 8'h01, 8'h80, CHK_GOOD, 8'h00, 8'h66, 8'h99,
                                       CHK_GOOD, 8'h00, 0, 0, 0, 0, ST_OK));

        // Reset held low from the start, released at a clock edge.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        presence_now = 1'b1;

        // Directed rows, with the register rewritten whenever a row needs another value.
        send_idle_pct = 25;
        recv_idle_pct = 69;
        foreach (directed_rows[k])
        begin
            row = directed_rows[k];
            if (row.present != presence_now)
            begin
                wait_all_taken();
                write_presence(row.present);
                presence_now = row.present;
            end
            typed_notes.push_back(row);
            send_frame(apply_checks(row.frame, row.tmode, row.hmode));
        end

        // Random segments: receiver-heavy idling, then sender-heavy, then none at all.
        for (s = 0; s < 6; s++)
        begin
            wait_all_taken();
            write_presence(seg_present[s]);
            send_idle_pct = (s < 2) ? 25 : (s < 4) ? 69 : 0;
            recv_idle_pct = (s < 2) ? 69 : (s < 4) ? 25 : 0;
            repeat (seg_items[s]) send_frame(random_frame());
        end

        wait_all_taken();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && pending_readings.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[files.f]
src/csa_pkg.sv
src/csa_front.sv
src/csa_queue.sv
src/csa_back.sv
src/checked_sensor_sample_averager.sv
bench/tb.sv
